>>> rtl/wvms_pkg.sv
// Shared widths and constants for the windowed vector magnitude sum block.
`default_nettype none

package wvms_pkg;

  localparam int CH_W          = 2;
  localparam int AXIS_W        = 16;
  localparam int TIME_W        = 32;
  localparam int SUM_W         = 32;
  localparam int INTERVAL_W    = 16;
  localparam int SQ_W          = 32;
  localparam int ROOT_W        = SQ_W / 2;
  localparam int ITER_W        = $clog2(ROOT_W);
  localparam int REM_W         = ROOT_W + 2;

  localparam int MAX_PORT_CH      = 4;
  localparam int NUM_CHANNELS_DEF = 4;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd2500;

endpackage

`default_nettype wire

>>> rtl/windowed_vector_magnitude_sum.sv
// Top level: sequencer, shared squarer, window check and per-channel sums.
//
// Input channel: in_valid_i/in_ready_o moves one sample word (channel, three
// signed Q6.9 axes, ms timestamp). The block takes one word at a time and
// drops ready until that word is done. A word whose channel is not below
// min(NUM_CHANNELS, 4) is taken and dropped, and ready stays high.
// A channel-0 word whose elapsed time since the window start exceeds
// interval_ms first emits every channel's sum, one word per output
// handshake on out_valid_o/out_ready_i, then clears the sums. The first sum
// goes into the output register from the report state, once that register is free.
// The output is a single register: a stalled receiver holds the report in
// progress, and with it the magnitude work of the current word and the input.
// Per word: the block takes it, loads one report word per free output slot
// when the word closes a window, squares the three axes on the shared 16x16
// squarer, starts the bit-per-cycle square root unit, and adds the root into
// the channel's sum. The square root loop is the longest step.
// cfg_valid_i/cfg_ready_o writes interval_ms; it is always ready.
// Reset sets interval_ms to 2500, the window start to 0, all sums to 0.
`default_nettype none

module windowed_vector_magnitude_sum #(
  parameter int NUM_CHANNELS = wvms_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [wvms_pkg::CH_W-1:0]         channel_i,
  input  wire logic signed [wvms_pkg::AXIS_W-1:0] axis_x_i,
  input  wire logic signed [wvms_pkg::AXIS_W-1:0] axis_y_i,
  input  wire logic signed [wvms_pkg::AXIS_W-1:0] axis_z_i,
  input  wire logic [wvms_pkg::TIME_W-1:0]       time_ms_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [wvms_pkg::CH_W-1:0]              out_channel_o,
  output logic [wvms_pkg::SUM_W-1:0]             window_sum_o,
  output logic                                   last_of_run_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [wvms_pkg::INTERVAL_W-1:0]   cfg_data_i
);

  localparam int ACT = (NUM_CHANNELS < wvms_pkg::MAX_PORT_CH) ?
                       NUM_CHANNELS : wvms_pkg::MAX_PORT_CH;
  localparam int CIW = (ACT > 1) ? $clog2(ACT) : 1;
  localparam int AW  = wvms_pkg::AXIS_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REPORT,
    S_SQUARE,
    S_ROOT
  } state_e;

  state_e                              state_q;
  logic [wvms_pkg::INTERVAL_W-1:0]     interval_q;
  logic [wvms_pkg::TIME_W-1:0]         window_start_q;
  logic [wvms_pkg::SUM_W-1:0]          sums_q [ACT];
  logic [wvms_pkg::CH_W-1:0]           ch_q;
  logic [AW-1:0]                       mag_q [3];
  logic [1:0]                          sq_cnt_q;
  logic [2*AW-1:0]                     prod_q;
  logic [wvms_pkg::SQ_W-1:0]           ssq_q;
  logic                                sqrt_start_q;
  logic [CIW-1:0]                      rep_idx_q;
  logic                                out_valid_q;
  logic [wvms_pkg::CH_W-1:0]           out_channel_q;
  logic [wvms_pkg::SUM_W-1:0]          window_sum_q;
  logic                                last_q;

  logic                                in_acc;
  logic                                ch_active;
  logic [wvms_pkg::TIME_W-1:0]         elapsed;
  logic                                win_over;
  logic [AW-1:0]                       mul_a;
  logic                                out_free;
  logic                                sqrt_busy;
  logic                                sqrt_done;
  logic [wvms_pkg::ROOT_W-1:0]         sqrt_root;
  logic [wvms_pkg::SUM_W:0]            acc_sum;

  function automatic logic [AW-1:0] abs16(input logic [AW-1:0] v);
    abs16 = v[AW-1] ? AW'(~v + 1'b1) : v;
  endfunction

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign ch_active  = (32'(channel_i) < ACT);
  assign elapsed    = time_ms_i - window_start_q;
  assign win_over   = (elapsed > wvms_pkg::TIME_W'(interval_q));
  assign out_free   = !out_valid_q || out_ready_i;
  assign acc_sum    = {1'b0, sums_q[ch_q[CIW-1:0]]} + (wvms_pkg::SUM_W + 1)'(sqrt_root);
  assign cfg_ready_o = 1'b1;

  // One multiplier serves all three axes.
  always_comb begin
    case (sq_cnt_q)
      2'd0:    mul_a = mag_q[0];
      2'd1:    mul_a = mag_q[1];
      2'd2:    mul_a = mag_q[2];
      default: mul_a = '0;
    endcase
  end

  wvms_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start_q),
    .op_i    (ssq_q),
    .busy_o  (sqrt_busy),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      interval_q     <= wvms_pkg::INTERVAL_RESET;
      window_start_q <= '0;
      for (int i = 0; i < ACT; i++) sums_q[i] <= '0;
      sqrt_start_q   <= 1'b0;
      out_valid_q    <= 1'b0;
      sq_cnt_q       <= '0;
      rep_idx_q      <= '0;
    end else begin
      sqrt_start_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        interval_q <= cfg_data_i;
      end
      // The report state reloads the output register itself.
      if (out_valid_q && out_ready_i && (state_q != S_REPORT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && ch_active) begin
            ch_q     <= channel_i;
            mag_q[0] <= abs16(axis_x_i);
            mag_q[1] <= abs16(axis_y_i);
            mag_q[2] <= abs16(axis_z_i);
            sq_cnt_q <= '0;
            ssq_q    <= '0;
            if ((channel_i == '0) && win_over) begin
              window_start_q <= time_ms_i;
              rep_idx_q      <= '0;
              state_q        <= S_REPORT;
            end else begin
              state_q <= S_SQUARE;
            end
          end
        end
        S_REPORT: begin
          // Load one sum per free output slot, clearing it as it leaves.
          if (out_free) begin
            out_valid_q       <= 1'b1;
            out_channel_q     <= wvms_pkg::CH_W'(rep_idx_q);
            window_sum_q      <= sums_q[rep_idx_q];
            sums_q[rep_idx_q] <= '0;
            last_q            <= (rep_idx_q == CIW'(ACT - 1));
            if (rep_idx_q == CIW'(ACT - 1)) begin
              state_q <= S_SQUARE;
            end else begin
              rep_idx_q <= rep_idx_q + 1'b1;
            end
          end
        end
        S_SQUARE: begin
          prod_q   <= (2*AW)'(mul_a) * (2*AW)'(mul_a);
          sq_cnt_q <= sq_cnt_q + 1'b1;
          if (sq_cnt_q != 2'd0) begin
            ssq_q <= ssq_q + wvms_pkg::SQ_W'(prod_q);
          end
          if (sq_cnt_q == 2'd3) begin
            sqrt_start_q <= 1'b1;
            state_q      <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (sqrt_done) begin
            sums_q[ch_q[CIW-1:0]] <= acc_sum[wvms_pkg::SUM_W] ? '1 :
                                     acc_sum[wvms_pkg::SUM_W-1:0];
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_channel_q;
  assign window_sum_o  = window_sum_q;
  assign last_of_run_o = last_q;

  a_last_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && last_q) |-> (32'(out_channel_q) == ACT - 1))
    else $error("last word of a report on the wrong channel");

  a_root_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_busy |-> (state_q == S_ROOT))
    else $error("square root running outside its state");

  a_report_then_square: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REPORT && out_free && rep_idx_q == CIW'(ACT - 1))
      |=> (state_q == S_SQUARE && sq_cnt_q == 2'd0))
    else $error("report did not hand over to the squarer");

endmodule

`default_nettype wire

>>> rtl/wvms_isqrt.sv
// Iterative floor square root, one result bit per cycle.
`default_nettype none

module wvms_isqrt (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [wvms_pkg::SQ_W-1:0]   op_i,
  output logic                             busy_o,
  output logic                             done_o,
  output logic [wvms_pkg::ROOT_W-1:0]      root_o
);

  logic [wvms_pkg::SQ_W-1:0]   op_q;
  logic [wvms_pkg::SQ_W-1:0]   work_q;
  logic [wvms_pkg::REM_W-1:0]  rem_q;
  logic [wvms_pkg::ROOT_W-1:0] root_q;
  logic [wvms_pkg::ITER_W-1:0] iter_q;
  logic                        busy_q;
  logic                        done_q;

  logic [wvms_pkg::REM_W+1:0]  rem_sh;
  logic [wvms_pkg::REM_W+1:0]  trial;
  logic                        fits;

  // Bring down the next two radicand bits and try to set the next root bit.
  assign rem_sh = {rem_q, work_q[wvms_pkg::SQ_W-1 -: 2]};
  assign trial  = (wvms_pkg::REM_W + 2)'({root_q, 2'b01});
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= '0;
        op_q   <= op_i;
        work_q <= op_i;
        rem_q  <= '0;
        root_q <= '0;
      end else if (busy_q) begin
        work_q <= {work_q[wvms_pkg::SQ_W-3:0], 2'b00};
        if (fits) begin
          rem_q  <= wvms_pkg::REM_W'(rem_sh - trial);
          root_q <= {root_q[wvms_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem_q  <= wvms_pkg::REM_W'(rem_sh);
          root_q <= {root_q[wvms_pkg::ROOT_W-2:0], 1'b0};
        end
        iter_q <= iter_q + 1'b1;
        if (iter_q == wvms_pkg::ITER_W'(wvms_pkg::ROOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign root_o = root_q;

  a_root_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ((64'(root_q) * 64'(root_q)) <= 64'(op_q)) &&
               ((64'(root_q) + 64'd1) * (64'(root_q) + 64'd1) > 64'(op_q)))
    else $error("isqrt result is not the floor root");

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("isqrt started while busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("isqrt done while still busy");

endmodule

`default_nettype wire

>>> dv/windowed_vector_magnitude_sum_tb.sv
// Self-checking testbench for the windowed vector magnitude sum block.
`timescale 1ns / 100ps

module windowed_vector_magnitude_sum_tb;

  localparam int NUM_CH = (wvms_pkg::NUM_CHANNELS_DEF < wvms_pkg::MAX_PORT_CH) ?
                          wvms_pkg::NUM_CHANNELS_DEF : wvms_pkg::MAX_PORT_CH;
  localparam int SETTLE_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int MAX_REPORTED = 10;

  typedef struct packed {
    logic [wvms_pkg::CH_W-1:0]  chan;
    logic [wvms_pkg::SUM_W-1:0] sum;
    logic                       last;
  } window_word_t;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               in_valid_i;
  logic                               in_ready_o;
  logic [wvms_pkg::CH_W-1:0]          channel_i;
  logic signed [wvms_pkg::AXIS_W-1:0] axis_x_i;
  logic signed [wvms_pkg::AXIS_W-1:0] axis_y_i;
  logic signed [wvms_pkg::AXIS_W-1:0] axis_z_i;
  logic [wvms_pkg::TIME_W-1:0]        time_ms_i;
  logic                               out_valid_o;
  logic                               out_ready_i;
  logic [wvms_pkg::CH_W-1:0]          out_channel_o;
  logic [wvms_pkg::SUM_W-1:0]         window_sum_o;
  logic                               last_of_run_o;
  logic                               cfg_valid_i;
  logic                               cfg_ready_o;
  logic [wvms_pkg::INTERVAL_W-1:0]    cfg_data_i;

  // Predictor state
  logic [wvms_pkg::INTERVAL_W-1:0] interval_m;
  logic [wvms_pkg::TIME_W-1:0]     win_start_m;
  logic [wvms_pkg::SUM_W-1:0]      sums_m [NUM_CH];
  window_word_t                    expected_sums_q [$];

  int  mismatches;
  int  samples_sent;
  int  sums_seen;
  int  reports_made;
  int  cfg_writes;
  bit  stall_en;
  bit  rx_hold_req;

  windowed_vector_magnitude_sum dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .channel_i     (channel_i),
    .axis_x_i      (axis_x_i),
    .axis_y_i      (axis_y_i),
    .axis_z_i      (axis_z_i),
    .time_ms_i     (time_ms_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_channel_o (out_channel_o),
    .window_sum_o  (window_sum_o),
    .last_of_run_o (last_of_run_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Floor square root of x^2 + y^2 + z^2, one result bit per pass.
  function automatic logic [wvms_pkg::ROOT_W-1:0] vec_magnitude(
      logic signed [wvms_pkg::AXIS_W-1:0] x,
      logic signed [wvms_pkg::AXIS_W-1:0] y,
      logic signed [wvms_pkg::AXIS_W-1:0] z);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned bitv;
    rem = longint'(x) * longint'(x) + longint'(y) * longint'(y) + longint'(z) * longint'(z);
    root = 0;
    bitv = 64'd1 << 32;
    repeat (17) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root[wvms_pkg::ROOT_W-1:0];
  endfunction

  function automatic void accumulate_sample(logic [wvms_pkg::CH_W-1:0] ch,
                                            logic signed [wvms_pkg::AXIS_W-1:0] x,
                                            logic signed [wvms_pkg::AXIS_W-1:0] y,
                                            logic signed [wvms_pkg::AXIS_W-1:0] z,
                                            logic [wvms_pkg::TIME_W-1:0] t);
    logic [wvms_pkg::TIME_W-1:0] elapsed;
    logic [wvms_pkg::SUM_W:0]    total;
    window_word_t                w;
    int                          c;
    if (int'(ch) >= NUM_CH) return;
    elapsed = t - win_start_m;
    // Close the window first: report sums as they stood, then clear.
    if (ch == '0 && elapsed > wvms_pkg::TIME_W'(interval_m)) begin
      for (c = 0; c < NUM_CH; c++) begin
        w.chan = wvms_pkg::CH_W'(c);
        w.sum  = sums_m[c];
        w.last = (c == NUM_CH - 1);
        expected_sums_q.push_back(w);
        sums_m[c] = '0;
      end
      win_start_m = t;
      reports_made++;
    end
    total = {1'b0, sums_m[ch]} + (wvms_pkg::SUM_W + 1)'(vec_magnitude(x, y, z));
    sums_m[ch] = total[wvms_pkg::SUM_W] ? '1 : total[wvms_pkg::SUM_W-1:0];
  endfunction

  function automatic void log_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTED) $display("ERROR @%0t: %s", $time, msg);
  endfunction

  function automatic logic signed [wvms_pkg::AXIS_W-1:0] pick_axis();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return '0;
      default: return wvms_pkg::AXIS_W'($urandom());
    endcase
  endfunction

  // Offer one sample word; valid stays high after acceptance until the next action.
  task automatic send_sample(input logic [wvms_pkg::CH_W-1:0] ch,
                             input logic signed [wvms_pkg::AXIS_W-1:0] x,
                             input logic signed [wvms_pkg::AXIS_W-1:0] y,
                             input logic signed [wvms_pkg::AXIS_W-1:0] z,
                             input logic [wvms_pkg::TIME_W-1:0] t);
    int gap;
    if (stall_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    channel_i  = ch;
    axis_x_i   = x;
    axis_y_i   = y;
    axis_z_i   = z;
    time_ms_i  = t;
    do @(posedge clk_i); while (!in_ready_o);
    accumulate_sample(ch, x, y, z, t);
    samples_sent++;
  endtask

  task automatic wait_for_drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_sums_q.size() != 0) @(posedge clk_i);
    // The last word may still be in the square root loop.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_interval(input logic [wvms_pkg::INTERVAL_W-1:0] ivl);
    wait_for_drain();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = ivl;
    do @(posedge clk_i); while (!cfg_ready_o);
    interval_m = ivl;
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Reset interval: window start 0, boundary at exactly the interval, axis extremes.
  task automatic test_reset_window();
    send_sample(2'd0, 16'sh8000, 16'sh8000, 16'sh8000, 32'd0);
    send_sample(2'd1, 16'sh7fff, 16'sh7fff, 16'sh7fff, 32'd10);
    send_sample(2'd2, 16'sh0000, 16'sh0000, 16'sh0000, 32'd20);
    send_sample(2'd3, -16'sd1, 16'sd1, 16'sh7fff, 32'd30);
    send_sample(2'd0, 16'sd512, -16'sd512, 16'sd0, 32'd2500);
    send_sample(2'd0, 16'sd100, 16'sd200, 16'sd300, 32'd2501);
    send_sample(2'd1, 16'sh8000, 16'sh7fff, 16'sd0, 32'd2600);
  endtask

  // Zero interval: any nonzero elapsed time closes the window.
  task automatic test_interval_zero();
    logic [wvms_pkg::TIME_W-1:0] t0;
    program_interval(16'd0);
    t0 = win_start_m;
    send_sample(2'd0, 16'sd1, 16'sd1, 16'sd1, t0);
    send_sample(2'd2, 16'sh5555, 16'shaaaa, 16'sh1234, t0);
    send_sample(2'd0, 16'sd9, 16'sd0, 16'sd0, t0 + 1);
    send_sample(2'd0, 16'sd0, 16'sd0, -16'sd7, t0 + 1);
  endtask

  // Widest interval, timestamp wrap and a timestamp that goes backward.
  task automatic test_interval_wrap();
    logic [wvms_pkg::TIME_W-1:0] t0;
    program_interval(16'hffff);
    t0 = win_start_m;
    send_sample(2'd0, 16'sd3, 16'sd4, 16'sd0, t0 + 32'd65535);
    send_sample(2'd0, 16'sd6, 16'sd8, 16'sd0, t0 + 32'd65536);
    send_sample(2'd0, 16'sh8000, 16'sd0, 16'sh7fff, 32'hffff_ff00);
    send_sample(2'd3, 16'sd1000, 16'sd2000, -16'sd3000, 32'hffff_ffff);
    send_sample(2'd0, 16'sd5, 16'sd12, 16'sd0, 32'h0000_feff);
    send_sample(2'd0, 16'sd8, 16'sd15, 16'sd0, 32'h0000_ff00);
    send_sample(2'd0, -16'sd2, 16'sd3, 16'sd6, 32'h0000_fe00);
  endtask

  // Random samples around the window boundary; pause for a full drain halfway.
  task automatic test_random_windows(input int count,
                                     input logic [wvms_pkg::INTERVAL_W-1:0] ivl);
    logic [wvms_pkg::TIME_W-1:0] t;
    int i;
    int r;
    program_interval(ivl);
    t = win_start_m;
    for (i = 0; i < count; i++) begin
      if (i == count / 2) wait_for_drain();
      r = $urandom_range(0, 19);
      if (r == 0) t = $urandom();
      else if (r == 1) t = t - $urandom_range(1, 100);
      else t = t + $urandom_range(0, int'(ivl) / 3 + 1);
      send_sample(wvms_pkg::CH_W'($urandom_range(0, 3)), pick_axis(), pick_axis(),
                  pick_axis(), t);
    end
  endtask

  // Receiver holds off while channel-0 words keep closing windows.
  task automatic test_output_backpressure();
    logic [wvms_pkg::TIME_W-1:0] t;
    program_interval(16'd0);
    rx_hold_req = 1'b1;
    t = win_start_m;
    repeat (12) begin
      t = t + $urandom_range(1, 50);
      send_sample(2'd0, pick_axis(), pick_axis(), pick_axis(), t);
    end
  endtask

  // Receiver: random stall bursts, plus one long hold on request.
  initial begin : rx_ready_gen
    int hold;
    int burst;
    hold = 0;
    burst = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold = RX_HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_ready_i = 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_ready_i = 1'b0;
      end else if (stall_en && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 10) - 1;
        out_ready_i = 1'b0;
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_sums
    window_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      sums_seen++;
      if (expected_sums_q.size() == 0) begin
        log_mismatch($sformatf("unexpected word: ch %0d sum %0d last %0b",
                               out_channel_o, window_sum_o, last_of_run_o));
      end else begin
        want = expected_sums_q.pop_front();
        if (want.chan !== out_channel_o || want.sum !== window_sum_o ||
            want.last !== last_of_run_o)
          log_mismatch($sformatf("exp ch %0d sum %0d last %0b, got ch %0d sum %0d last %0b",
                                 want.chan, want.sum, want.last,
                                 out_channel_o, window_sum_o, last_of_run_o));
      end
    end
  end

  // Abort when no channel moves a word for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout after %0d idle cycles", WATCHDOG_LIMIT);
    $display("windowed_vector_magnitude_sum: mismatch");
    $finish;
  end

  initial begin : run_tests
    int c;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    channel_i   = '0;
    axis_x_i    = '0;
    axis_y_i    = '0;
    axis_z_i    = '0;
    time_ms_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    stall_en    = 1'b1;
    rx_hold_req = 1'b0;
    mismatches  = 0;
    samples_sent = 0;
    sums_seen   = 0;
    reports_made = 0;
    cfg_writes  = 0;
    interval_m  = wvms_pkg::INTERVAL_RESET;
    win_start_m = '0;
    for (c = 0; c < NUM_CH; c++) sums_m[c] = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_window();
    test_interval_zero();
    test_interval_wrap();
    test_random_windows(16, wvms_pkg::INTERVAL_W'($urandom_range(1, 65534)));
    test_output_backpressure();
    test_random_windows(16, 16'd0);
    test_random_windows(16, 16'hffff);
    test_random_windows(16, wvms_pkg::INTERVAL_W'($urandom_range(1, 60)));
    stall_en = 1'b0;
    test_random_windows(16, wvms_pkg::INTERVAL_RESET);
    wait_for_drain();

    if (expected_sums_q.size() != 0)
      log_mismatch($sformatf("%0d window words never arrived", expected_sums_q.size()));
    $display("covered %0d samples over %0d interval settings, incl. wrap, backward time, stalls",
             samples_sent, cfg_writes + 1);
    $display("checked %0d window words from %0d reports, %0d mismatches",
             sums_seen, reports_made, mismatches);
    if (mismatches == 0)
      $display("windowed_vector_magnitude_sum: match");
    else
      $display("windowed_vector_magnitude_sum: mismatch");
    $finish;
  end

endmodule
